/* rtl/pid_deadzone_controller_defines.svh */
// Assertion macros used by the controller checker file
`ifndef PID_DEADZONE_CONTROLLER_DEFINES_SVH
`define PID_DEADZONE_CONTROLLER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted
`define PDC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("pdc same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define PDC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("pdc next-cycle check failed");

`endif

/* rtl/pdc_pkg.sv */
// Package: widths, register indexes and shared types of the PID dead-zone controller
package pdc_pkg;

	// fixed-point format
	localparam int DATA_WIDTH = 16;
	localparam int FRAC_BITS  = 8;
	localparam int ACC_WIDTH  = 24;

	// derived widths
	localparam int ERR_W  = DATA_WIDTH + 1;
	localparam int DER_W  = DATA_WIDTH + 2;
	localparam int LIM_W  = ACC_WIDTH - 1;
	localparam int INT_W  = ((ACC_WIDTH > ERR_W) ? ACC_WIDTH : ERR_W) + 1;
	localparam int PP_W   = DATA_WIDTH + ERR_W;
	localparam int PI_W   = DATA_WIDTH + ACC_WIDTH;
	localparam int PD_W   = DATA_WIDTH + DER_W;
	localparam int PMAX_W = (PI_W > PD_W) ? PI_W : PD_W;
	localparam int SUM_W  = PMAX_W + 2;

	// configuration port
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = (DATA_WIDTH > LIM_W) ? DATA_WIDTH : LIM_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_TARGET  = 3'd0,
		REG_KP      = 3'd1,
		REG_KI      = 3'd2,
		REG_KD      = 3'd3,
		REG_UPPER   = 3'd4,
		REG_LOWER   = 3'd5,
		REG_WINDUP  = 3'd6,
		REG_DEADBND = 3'd7
	} cfg_reg_t;

	// register file contents
	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] target;
		logic signed [DATA_WIDTH-1:0] kp;
		logic signed [DATA_WIDTH-1:0] ki;
		logic signed [DATA_WIDTH-1:0] kd;
		logic signed [DATA_WIDTH-1:0] upper;
		logic signed [DATA_WIDTH-1:0] lower;
		logic        [LIM_W-1:0]      windup;
		logic        [DATA_WIDTH-1:0] deadband;
	} cfg_t;

	// one result from the control core
	typedef struct packed {
		logic signed [DATA_WIDTH-1:0] drive;
		logic                         hold;
	} res_t;

endpackage

/* rtl/pdc_cfg_regs.sv */
// Configuration register file of the PID dead-zone controller
module pdc_cfg_regs (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               cfg_we,
	input  logic [pdc_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [pdc_pkg::CFG_DATA_W-1:0]     cfg_data,
	output pdc_pkg::cfg_t                      cfg
);

	pdc_pkg::cfg_t cfg_q;

	// register writes, decoded by index
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target   <= '0;
			cfg_q.kp       <= '0;
			cfg_q.ki       <= '0;
			cfg_q.kd       <= '0;
			cfg_q.upper    <= {1'b0, {(pdc_pkg::DATA_WIDTH-1){1'b1}}};
			cfg_q.lower    <= {1'b1, {(pdc_pkg::DATA_WIDTH-1){1'b0}}};
			cfg_q.windup   <= '1;
			cfg_q.deadband <= '0;
		end else if (cfg_we) begin
			unique case (pdc_pkg::cfg_reg_t'(cfg_index))
				pdc_pkg::REG_TARGET:  cfg_q.target   <= cfg_data[pdc_pkg::DATA_WIDTH-1:0];
				pdc_pkg::REG_KP:      cfg_q.kp       <= cfg_data[pdc_pkg::DATA_WIDTH-1:0];
				pdc_pkg::REG_KI:      cfg_q.ki       <= cfg_data[pdc_pkg::DATA_WIDTH-1:0];
				pdc_pkg::REG_KD:      cfg_q.kd       <= cfg_data[pdc_pkg::DATA_WIDTH-1:0];
				pdc_pkg::REG_UPPER:   cfg_q.upper    <= cfg_data[pdc_pkg::DATA_WIDTH-1:0];
				pdc_pkg::REG_LOWER:   cfg_q.lower    <= cfg_data[pdc_pkg::DATA_WIDTH-1:0];
				pdc_pkg::REG_WINDUP:  cfg_q.windup   <= cfg_data[pdc_pkg::LIM_W-1:0];
				pdc_pkg::REG_DEADBND: cfg_q.deadband <= cfg_data[pdc_pkg::DATA_WIDTH-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

/* rtl/pdc_core.sv */
// Control core: error, dead zone, clamped integral, derivative, gain sum and output clamp
module pdc_core (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic                                kind,
	input  logic signed [pdc_pkg::DATA_WIDTH-1:0] meas,
	input  pdc_pkg::cfg_t                       cfg,
	output pdc_pkg::res_t                       res
);

	localparam int DW = pdc_pkg::DATA_WIDTH;

	// controller state
	logic signed [pdc_pkg::ACC_WIDTH-1:0] integ_q;
	logic signed [pdc_pkg::ERR_W-1:0]     prev_err_q;
	logic signed [DW-1:0]                 held_q;

	logic signed [pdc_pkg::ERR_W-1:0]     err;
	logic signed [pdc_pkg::ERR_W-1:0]     db_pos;
	logic signed [pdc_pkg::ERR_W-1:0]     db_neg;
	logic                                 hold;
	logic signed [pdc_pkg::INT_W-1:0]     integ_sum;
	logic signed [pdc_pkg::INT_W-1:0]     lim_pos;
	logic signed [pdc_pkg::INT_W-1:0]     lim_neg;
	logic signed [pdc_pkg::INT_W-1:0]     integ_clip;
	logic signed [pdc_pkg::ACC_WIDTH-1:0] integ_new;
	logic signed [pdc_pkg::DER_W-1:0]     deriv;
	logic signed [pdc_pkg::PP_W-1:0]      p_prop;
	logic signed [pdc_pkg::PI_W-1:0]      p_integ;
	logic signed [pdc_pkg::PD_W-1:0]      p_deriv;
	logic signed [pdc_pkg::SUM_W-1:0]     sum;
	logic signed [pdc_pkg::SUM_W-1:0]     scaled;
	logic signed [pdc_pkg::SUM_W-1:0]     hi_x;
	logic signed [pdc_pkg::SUM_W-1:0]     lo_x;
	logic signed [pdc_pkg::SUM_W-1:0]     clip_hi;
	logic signed [pdc_pkg::SUM_W-1:0]     clip_lo;
	logic signed [DW-1:0]                 drive_new;

	// error and dead-zone test (strictly inside)
	assign err    = $signed({meas[DW-1], meas}) - $signed({cfg.target[DW-1], cfg.target});
	assign db_pos = $signed({1'b0, cfg.deadband});
	assign db_neg = -db_pos;
	assign hold   = (err > db_neg) && (err < db_pos);

	// integral with symmetric saturation, upper bound first
	assign integ_sum = $signed({{(pdc_pkg::INT_W-pdc_pkg::ACC_WIDTH){integ_q[pdc_pkg::ACC_WIDTH-1]}},
	                            integ_q})
	                 + $signed({{(pdc_pkg::INT_W-pdc_pkg::ERR_W){err[pdc_pkg::ERR_W-1]}}, err});
	assign lim_pos   = $signed({{(pdc_pkg::INT_W-pdc_pkg::LIM_W){1'b0}}, cfg.windup});
	assign lim_neg   = -lim_pos;

	always_comb begin
		integ_clip = integ_sum;
		if (integ_clip > lim_pos) integ_clip = lim_pos;
		if (integ_clip < lim_neg) integ_clip = lim_neg;
	end

	assign integ_new = integ_clip[pdc_pkg::ACC_WIDTH-1:0];

	// derivative from the last updating error
	assign deriv = $signed({err[pdc_pkg::ERR_W-1], err})
	             - $signed({prev_err_q[pdc_pkg::ERR_W-1], prev_err_q});

	// three gain products at natural width, operands sign-extended to the product width
	assign p_prop  = $signed({{(pdc_pkg::PP_W-DW){cfg.kp[DW-1]}}, cfg.kp})
	               * $signed({{(pdc_pkg::PP_W-pdc_pkg::ERR_W){err[pdc_pkg::ERR_W-1]}}, err});
	assign p_integ = $signed({{(pdc_pkg::PI_W-DW){cfg.ki[DW-1]}}, cfg.ki})
	               * $signed({{(pdc_pkg::PI_W-pdc_pkg::ACC_WIDTH){integ_new[pdc_pkg::ACC_WIDTH-1]}},
	                          integ_new});
	assign p_deriv = $signed({{(pdc_pkg::PD_W-DW){cfg.kd[DW-1]}}, cfg.kd})
	               * $signed({{(pdc_pkg::PD_W-pdc_pkg::DER_W){deriv[pdc_pkg::DER_W-1]}}, deriv});

	assign sum = $signed({{(pdc_pkg::SUM_W-pdc_pkg::PP_W){p_prop[pdc_pkg::PP_W-1]}}, p_prop})
	           + $signed({{(pdc_pkg::SUM_W-pdc_pkg::PI_W){p_integ[pdc_pkg::PI_W-1]}}, p_integ})
	           + $signed({{(pdc_pkg::SUM_W-pdc_pkg::PD_W){p_deriv[pdc_pkg::PD_W-1]}}, p_deriv});

	// floor shift back to Q8.8
	assign scaled = sum >>> pdc_pkg::FRAC_BITS;

	// output clamp: upper first, then lower
	assign hi_x = $signed({{(pdc_pkg::SUM_W-DW){cfg.upper[DW-1]}}, cfg.upper});
	assign lo_x = $signed({{(pdc_pkg::SUM_W-DW){cfg.lower[DW-1]}}, cfg.lower});

	always_comb begin
		clip_hi = (scaled > hi_x) ? hi_x : scaled;
		clip_lo = (clip_hi < lo_x) ? lo_x : clip_hi;
	end

	assign drive_new = clip_lo[DW-1:0];

	// result selection
	always_comb begin
		if (kind) begin
			res.drive = '0;
			res.hold  = 1'b0;
		end else if (hold) begin
			res.drive = held_q;
			res.hold  = 1'b1;
		end else begin
			res.drive = drive_new;
			res.hold  = 1'b0;
		end
	end

	// state update on each processed beat; a dead-zone beat leaves the state unchanged
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			integ_q    <= '0;
			prev_err_q <= '0;
			held_q     <= '0;
		end else if (step) begin
			if (kind) begin
				integ_q    <= '0;
				prev_err_q <= '0;
				held_q     <= '0;
			end else if (!hold) begin
				integ_q    <= integ_new;
				prev_err_q <= err;
				held_q     <= drive_new;
			end
		end
	end

endmodule

/* rtl/pid_deadzone_controller.sv */
// Top level of the PID dead-zone controller: input stage, core, output stage
//
// Channel | Signals                                       | Direction
// --------+-----------------------------------------------+----------
// input   | in_valid, in_ready, kind, measured_value       | in
// output  | out_valid, out_ready, drive_value, in_deadband | out
// config  | cfg_we, cfg_index, cfg_data                    | in
//
// One beat per cycle sustained while out_ready stays high; each accepted beat
// passes through the input register, then through the core into the output register.
// The rate is set by the state recurrence in the core.
// Reset clears the handshake state, the controller state and the configuration
// registers to their defaults. A stalled output holds the input stage, which then
// drops in_ready; no beat is lost or repeated.
module pid_deadzone_controller (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_we,
	input  logic [pdc_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [pdc_pkg::CFG_DATA_W-1:0]        cfg_data,
	input  logic                                  in_valid,
	output logic                                  in_ready,
	input  logic                                  kind,
	input  logic signed [pdc_pkg::DATA_WIDTH-1:0] measured_value,
	output logic                                  out_valid,
	input  logic                                  out_ready,
	output logic signed [pdc_pkg::DATA_WIDTH-1:0] drive_value,
	output logic                                  in_deadband
);

	pdc_pkg::cfg_t cfg;
	pdc_pkg::res_t res;

	logic                                  valid_s1;
	logic                                  kind_s1;
	logic signed [pdc_pkg::DATA_WIDTH-1:0] meas_s1;
	logic                                  valid_s2;
	logic signed [pdc_pkg::DATA_WIDTH-1:0] drive_s2;
	logic                                  hold_s2;
	logic                                  advance;
	logic                                  step;

	// flow control
	assign advance  = !valid_s2 || out_ready;
	assign in_ready = !valid_s1 || advance;
	assign step     = valid_s1 && advance;

	pdc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	pdc_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (step),
		.kind   (kind_s1),
		.meas   (meas_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// input stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			kind_s1 <= kind;
			meas_s1 <= measured_value;
		end
	end

	// output stage
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			drive_s2 <= res.drive;
			hold_s2  <= res.hold;
		end
	end

	assign out_valid   = valid_s2;
	assign drive_value = drive_s2;
	assign in_deadband = hold_s2;

endmodule

/* rtl/pdc_checker.sv */
// Port-level checker for the PID dead-zone controller, with its bind
`include "pid_deadzone_controller_defines.svh"

module pdc_checker (
	input logic                                  clk,
	input logic                                  arst_n,
	input logic                                  in_ready,
	input logic                                  out_valid,
	input logic                                  out_ready,
	input logic signed [pdc_pkg::DATA_WIDTH-1:0] drive_value,
	input logic                                  in_deadband
);

	// last delivered output, which is what a dead-zone beat repeats
	logic signed [pdc_pkg::DATA_WIDTH-1:0] last_drive_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_drive_q <= '0;
		end else if (out_valid && out_ready) begin
			last_drive_q <= drive_value;
		end
	end

	// stalled result beat holds
	`PDC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && !out_ready, out_valid && $stable(drive_value) && $stable(in_deadband))

	// held beat repeats the previous output
	`PDC_ASSERT_IMPL(a_deadband_repeat, clk, arst_n, out_valid && in_deadband, drive_value == last_drive_q)

	// with the output register empty the block always takes a beat
	`PDC_ASSERT_IMPL(a_ready_when_empty, clk, arst_n, !out_valid, in_ready)

endmodule

bind pid_deadzone_controller pdc_checker u_pdc_checker (
	.clk         (clk),
	.arst_n      (arst_n),
	.in_ready    (in_ready),
	.out_valid   (out_valid),
	.out_ready   (out_ready),
	.drive_value (drive_value),
	.in_deadband (in_deadband)
);

/* test/pid_deadzone_controller_tb.sv */
`timescale 1ns / 100ps
// Self-checking testbench for the PID dead-zone controller: reset defaults and directed cases, then random phases
module pid_deadzone_controller_tb;

	localparam logic KIND_MEASURE = 1'b0;
	localparam logic KIND_CLEAR   = 1'b1;
	localparam int   RANDOM_BEATS = 1950;
	localparam int   QUIET_LIMIT  = 4000;
	localparam int   REPORT_MAX   = 10;
	localparam int   DW           = pdc_pkg::DATA_WIDTH;
	localparam int   LW           = pdc_pkg::LIM_W;

	typedef enum int {
		READY_ALWAYS,
		READY_RANDOM,
		READY_PERIODIC,
		READY_BURSTY
	} ready_mode_t;

	// DUT ports
	logic                                  clk            = 1'b0;
	logic                                  arst_n         = 1'b0;
	logic                                  cfg_we         = 1'b0;
	logic [pdc_pkg::CFG_IDX_W-1:0]         cfg_index      = '0;
	logic [pdc_pkg::CFG_DATA_W-1:0]        cfg_data       = '0;
	logic                                  in_valid       = 1'b0;
	logic                                  in_ready;
	logic                                  kind           = KIND_MEASURE;
	logic signed [DW-1:0]                  measured_value = '0;
	logic                                  out_valid;
	logic                                  out_ready      = 1'b0;
	logic signed [DW-1:0]                  drive_value;
	logic                                  in_deadband;

	// shadow of the register file, at reset defaults
	logic signed [DW-1:0] set_point   = '0;
	logic signed [DW-1:0] gain_p      = '0;
	logic signed [DW-1:0] gain_i      = '0;
	logic signed [DW-1:0] gain_d      = '0;
	logic signed [DW-1:0] drive_hi    = {1'b0, {(DW-1){1'b1}}};
	logic signed [DW-1:0] drive_lo    = {1'b1, {(DW-1){1'b0}}};
	logic        [LW-1:0] integ_limit = '1;
	logic        [DW-1:0] hold_band   = '0;

	// controller state as the predictor sees it
	logic signed [pdc_pkg::ACC_WIDTH-1:0] integ_state = '0;
	logic signed [pdc_pkg::ERR_W-1:0]     err_state   = '0;
	logic signed [DW-1:0]                 drive_state = '0;

	pdc_pkg::res_t pending_drive[$];
	pdc_pkg::res_t head_result;

	int mismatches      = 0;
	int results_checked = 0;
	int beats_sent      = 0;
	int clears_sent     = 0;
	int holds_seen      = 0;
	int settings_loaded = 0;
	int quiet_cycles    = 0;
	int burst_left      = 0;
	bit sender_gaps     = 1'b1;

	ready_mode_t ready_mode = READY_ALWAYS;
	int          mode_left    = 0;
	int          ready_period = 2;
	int          ready_tick   = 0;
	int          hold_left    = 0;

	pid_deadzone_controller DUT (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.measured_value (measured_value),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.drive_value    (drive_value),
		.in_deadband    (in_deadband)
	);

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// next output of the controller for one accepted beat; advances the shadow state
	function automatic pdc_pkg::res_t predict_drive(input logic k,
			input logic signed [DW-1:0] meas);
		pdc_pkg::res_t r;
		longint        err, band, lim, integ, deriv, total, hi, lo;
		r.drive = '0;
		r.hold  = 1'b0;
		if (k == KIND_CLEAR) begin
			integ_state = '0;
			err_state   = '0;
			drive_state = '0;
			return r;
		end
		err  = longint'(meas) - longint'(set_point);
		band = longint'(hold_band);
		// strictly inside the dead zone: repeat the held output, state untouched
		if (err > -band && err < band) begin
			r.drive = drive_state;
			r.hold  = 1'b1;
			return r;
		end
		// integral with symmetric saturation
		lim   = longint'(integ_limit);
		integ = longint'(integ_state) + err;
		if (integ > lim)
			integ = lim;
		if (integ < -lim)
			integ = -lim;
		integ_state = integ[pdc_pkg::ACC_WIDTH-1:0];
		deriv = err - longint'(err_state);
		total = longint'(gain_p) * err + longint'(gain_i) * integ + longint'(gain_d) * deriv;
		total = total >>> pdc_pkg::FRAC_BITS;
		// upper clamp first, then lower
		hi = longint'(drive_hi);
		lo = longint'(drive_lo);
		if (total > hi)
			total = hi;
		if (total < lo)
			total = lo;
		drive_state = total[DW-1:0];
		err_state   = err[pdc_pkg::ERR_W-1:0];
		r.drive     = total[DW-1:0];
		return r;
	endfunction

	// Q8.8 value biased towards zero, small values and the extremes
	function automatic logic signed [DW-1:0] rand_q88();
		int pick;
		pick = $urandom_range(0, 7);
		case (pick)
			0: return {1'b1, {(DW-1){1'b0}}};
			1: return {1'b0, {(DW-1){1'b1}}};
			2: return '0;
			3, 4, 5: return DW'(int'($urandom_range(0, 2048)) - 1024);
			default: return DW'($urandom);
		endcase
	endfunction

	// one register write, shadow updated alongside
	task automatic set_register(input pdc_pkg::cfg_reg_t idx,
			input logic [pdc_pkg::CFG_DATA_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		@(negedge clk);
		cfg_we    <= 1'b0;
		case (idx)
			pdc_pkg::REG_TARGET:  set_point   = val[DW-1:0];
			pdc_pkg::REG_KP:      gain_p      = val[DW-1:0];
			pdc_pkg::REG_KI:      gain_i      = val[DW-1:0];
			pdc_pkg::REG_KD:      gain_d      = val[DW-1:0];
			pdc_pkg::REG_UPPER:   drive_hi    = val[DW-1:0];
			pdc_pkg::REG_LOWER:   drive_lo    = val[DW-1:0];
			pdc_pkg::REG_WINDUP:  integ_limit = val[LW-1:0];
			default:              hold_band   = val[DW-1:0];
		endcase
	endtask

	// full register set; only called with the pipeline drained
	task automatic load_settings(input logic [DW-1:0] tgt, input logic [DW-1:0] kp,
			input logic [DW-1:0] ki, input logic [DW-1:0] kd,
			input logic [DW-1:0] up, input logic [DW-1:0] lo,
			input logic [LW-1:0] wl, input logic [DW-1:0] db);
		set_register(pdc_pkg::REG_TARGET,  pdc_pkg::CFG_DATA_W'(tgt));
		set_register(pdc_pkg::REG_KP,      pdc_pkg::CFG_DATA_W'(kp));
		set_register(pdc_pkg::REG_KI,      pdc_pkg::CFG_DATA_W'(ki));
		set_register(pdc_pkg::REG_KD,      pdc_pkg::CFG_DATA_W'(kd));
		set_register(pdc_pkg::REG_UPPER,   pdc_pkg::CFG_DATA_W'(up));
		set_register(pdc_pkg::REG_LOWER,   pdc_pkg::CFG_DATA_W'(lo));
		set_register(pdc_pkg::REG_WINDUP,  pdc_pkg::CFG_DATA_W'(wl));
		set_register(pdc_pkg::REG_DEADBND, pdc_pkg::CFG_DATA_W'(db));
		settings_loaded++;
	endtask

	// send one beat: bursts of random length with random gaps in between
	task automatic send_sample(input logic k, input logic signed [DW-1:0] m);
		int            gap;
		pdc_pkg::res_t r;
		gap = 0;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 24);
			if (sender_gaps)
				gap = $urandom_range(0, 8);
		end
		if (gap > 0) begin
			@(negedge clk);
			in_valid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		in_valid       <= 1'b1;
		kind           <= k;
		measured_value <= m;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		r = predict_drive(k, m);
		pending_drive.push_back(r);
		burst_left--;
		beats_sent++;
		if (k == KIND_CLEAR)
			clears_sent++;
		if (r.hold)
			holds_seen++;
	endtask

	// idle the sender and wait for every outstanding result
	task automatic drain_pipeline();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_drive.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
		burst_left = 0;
	endtask

	// zero gains at reset: output stays 0, zero dead zone never holds
	task automatic test_reset_defaults();
		send_sample(KIND_MEASURE, 16'sh0000);
		send_sample(KIND_MEASURE, 16'sh7FFF);
		send_sample(KIND_MEASURE, -16'sh8000);
		send_sample(KIND_CLEAR, 16'sh1234);
		drain_pipeline();
	endtask

	// dead-zone edges, windup saturation, clear, crossed clamps, extreme gains
	task automatic test_directed_cases();
		load_settings(16'h0100, 16'h0100, 16'h0010, 16'h0080, 16'h7FFF, 16'h8000,
			LW'(24'h000800), 16'h0040);
		send_sample(KIND_MEASURE, 16'sh0100);   // zero error, held
		send_sample(KIND_MEASURE, 16'sh013F);   // just inside, held
		send_sample(KIND_MEASURE, 16'sh0140);   // on the edge, not held
		send_sample(KIND_MEASURE, 16'sh00C0);   // negative edge, not held
		send_sample(KIND_MEASURE, 16'sh7FFF);   // integral hits the positive limit
		send_sample(KIND_MEASURE, 16'sh7FFF);
		send_sample(KIND_MEASURE, -16'sh8000);
		send_sample(KIND_MEASURE, -16'sh8000);  // negative limit
		send_sample(KIND_CLEAR, 16'sh7FFF);
		send_sample(KIND_MEASURE, 16'sh0101);   // held output is 0 after clear
		drain_pipeline();

		// crossed clamps: lower above upper wins
		load_settings(16'h0100, 16'h0100, 16'h0010, 16'h0080, 16'hFF00, 16'h0100,
			LW'(24'h000800), 16'h0040);
		send_sample(KIND_MEASURE, 16'sh7FFF);
		send_sample(KIND_MEASURE, -16'sh8000);
		send_sample(KIND_MEASURE, 16'sh0100);
		drain_pipeline();

		// extreme gains and setpoint, full windup range, zero dead zone
		load_settings(16'h8000, 16'h7FFF, 16'h8000, 16'h7FFF, 16'h7FFF, 16'h8000,
			LW'(24'h7FFFFF), 16'h0000);
		send_sample(KIND_MEASURE, 16'sh7FFF);
		send_sample(KIND_MEASURE, -16'sh8000);  // zero error is not held
		send_sample(KIND_MEASURE, 16'sh7FFF);
		send_sample(KIND_CLEAR, -16'sh8000);
		send_sample(KIND_MEASURE, 16'sh0000);
		drain_pipeline();
	endtask

	// random register settings, each followed by a run of random beats
	task automatic test_random_phases();
		int                   phase_idx, phase_len, random_sent, n;
		logic [DW-1:0]        a, b, db;
		logic [LW-1:0]        wl;
		longint               span, v;
		logic                 k;
		logic signed [DW-1:0] m;
		phase_idx   = 0;
		random_sent = 0;
		while (random_sent < RANDOM_BEATS) begin
			if (phase_idx == 0) begin
				load_settings('1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1 >> 1, '1, '1);
			end else if (phase_idx == 1) begin
				load_settings(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000,
					'0, '0);
			end else begin
				// clamps mostly ordered, sometimes crossed
				a = rand_q88();
				b = rand_q88();
				if ($urandom_range(0, 3) != 0 && $signed(a) < $signed(b))
					{a, b} = {b, a};
				case ($urandom_range(0, 3))
					0: wl = '0;
					1: wl = '1;
					2: wl = LW'($urandom_range(0, 32'h10000));
					default: wl = LW'($urandom);
				endcase
				case ($urandom_range(0, 3))
					0: db = '0;
					1: db = DW'($urandom_range(1, 512));
					2: db = '1;
					default: db = DW'($urandom);
				endcase
				load_settings(rand_q88(), rand_q88(), rand_q88(), rand_q88(), a, b, wl, db);
			end
			sender_gaps = ($urandom_range(0, 3) != 0);
			phase_len   = $urandom_range(100, 250);
			// last phase stops at the planned beat count
			if (phase_len > RANDOM_BEATS - random_sent)
				phase_len = RANDOM_BEATS - random_sent;
			for (n = 0; n < phase_len; n++) begin
				k = ($urandom_range(0, 99) < 5) ? KIND_CLEAR : KIND_MEASURE;
				if ($urandom_range(0, 9) < 6) begin
					// near the setpoint so the dead zone and its edges are hit
					span = 2 * longint'(hold_band) + 256;
					v    = longint'(set_point) + longint'($urandom_range(0, 2 * span)) - span;
					if (v > 32767)
						v = 32767;
					if (v < -32768)
						v = -32768;
					m = v[DW-1:0];
				end else begin
					m = DW'($urandom);
				end
				send_sample(k, m);
			end
			random_sent += phase_len;
			drain_pipeline();
			phase_idx++;
		end
	endtask

	// receiver back-pressure: a pattern that is chosen anew whenever mode_left runs out
	always @(negedge clk) begin
		if (mode_left == 0) begin
			ready_mode   = ready_mode_t'($urandom_range(0, 3));
			mode_left    = $urandom_range(32, 256);
			ready_period = $urandom_range(2, 5);
		end
		mode_left--;
		ready_tick++;
		case (ready_mode)
			READY_ALWAYS:   out_ready <= 1'b1;
			READY_RANDOM:   out_ready <= ($urandom_range(0, 99) >= 35);
			READY_PERIODIC: out_ready <= ((ready_tick % ready_period) != 0);
			default: begin
				if (hold_left != 0) begin
					hold_left--;
					out_ready <= 1'b0;
				end else if ($urandom_range(0, 9) == 0) begin
					hold_left = $urandom_range(4, 20);
					out_ready <= 1'b0;
				end else begin
					out_ready <= 1'b1;
				end
			end
		endcase
	end

	// result checker: each output beat against the oldest prediction
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			results_checked++;
			if (pending_drive.size() == 0) begin
				mismatches++;
				if (mismatches <= REPORT_MAX)
					$display("ERROR: unexpected result drive=%0d hold=%0b at %0t",
						drive_value, in_deadband, $time);
			end else begin
				head_result = pending_drive.pop_front();
				if (drive_value !== head_result.drive || in_deadband !== head_result.hold) begin
					mismatches++;
					if (mismatches <= REPORT_MAX)
						$display("ERROR: result %0d: drive exp %0d got %0d, hold exp %0b got %0b",
							results_checked, head_result.drive, drive_value,
							head_result.hold, in_deadband);
				end
			end
		end
	end

	// watchdog: cycles in which no beat moves on either channel
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
	end

	initial begin
		while (quiet_cycles < QUIET_LIMIT) @(posedge clk);
		$display("ERROR: no handshake for %0d cycles", QUIET_LIMIT);
		$display("Test completed with failures");
		$finish;
	end

	// test sequence
	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_reset_defaults();
		test_directed_cases();
		test_random_phases();

		drain_pipeline();
		repeat (8) @(posedge clk);
		if (pending_drive.size() != 0)
			$display("ERROR: %0d results never arrived", pending_drive.size());
		$display("Sent %0d beats (%0d clears, %0d held in the dead zone) over %0d settings",
			beats_sent, clears_sent, holds_seen, settings_loaded);
		$display("Checked %0d result beats, %0d mismatches", results_checked, mismatches);
		if (mismatches == 0 && pending_drive.size() == 0)
			$display("Test completed successfully");
		else
			$display("Test completed with failures");
		$finish;
	end

endmodule
